// ===== rtl/core/csws_pkg.sv =====
// Shared types, constants and byte classes for the C source word scanner.
package csws_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 8;

  localparam logic [LenW-1:0] MaxLenReset = LenW'(99);

  localparam logic [ByteW-1:0] ChUnderscore = 8'h5F;
  localparam logic [ByteW-1:0] ChHash       = 8'h23;
  localparam logic [ByteW-1:0] ChStar       = 8'h2A;
  localparam logic [ByteW-1:0] ChSlash      = 8'h2F;
  localparam logic [ByteW-1:0] ChBackslash  = 8'h5C;
  localparam logic [ByteW-1:0] ChSquote     = 8'h27;
  localparam logic [ByteW-1:0] ChDquote     = 8'h22;

  typedef enum logic [6:0] {
    MODE_IDLE    = 7'b0000001,
    MODE_WORD    = 7'b0000010,
    MODE_LIT     = 7'b0000100,
    MODE_ESC     = 7'b0001000,
    MODE_SLASH   = 7'b0010000,
    MODE_COMMENT = 7'b0100000,
    MODE_STAR    = 7'b1000000
  } scan_mode_e;

  typedef struct packed {
    logic letter;
    logic digit;
    logic uscore;
    logic hash;
    logic squote;
    logic dquote;
    logic slash;
    logic star;
    logic bslash;
  } byte_class_t;

  typedef struct packed {
    scan_mode_e       mode;
    logic             quote_dq;
    logic [LenW-1:0]  tok_len;
    logic [ByteW-1:0] held;
    logic             held_vld;
  } scan_state_t;

  localparam scan_state_t ScanReset = '{
    mode:     MODE_IDLE,
    quote_dq: 1'b0,
    tok_len:  '0,
    held:     '0,
    held_vld: 1'b0
  };

endpackage

// ===== rtl/core/csws_classify.sv =====
// Byte classifier: decodes the character classes the scanner cares about.
module csws_classify (
  input  logic [csws_pkg::ByteW-1:0] byte_i,
  output csws_pkg::byte_class_t      class_o
);

  always_comb begin
    class_o.letter = ((byte_i >= 8'h41) && (byte_i <= 8'h5A)) ||
                     ((byte_i >= 8'h61) && (byte_i <= 8'h7A));
    class_o.digit  = (byte_i >= 8'h30) && (byte_i <= 8'h39);
    class_o.uscore = (byte_i == csws_pkg::ChUnderscore);
    class_o.hash   = (byte_i == csws_pkg::ChHash);
    class_o.squote = (byte_i == csws_pkg::ChSquote);
    class_o.dquote = (byte_i == csws_pkg::ChDquote);
    class_o.slash  = (byte_i == csws_pkg::ChSlash);
    class_o.star   = (byte_i == csws_pkg::ChStar);
    class_o.bslash = (byte_i == csws_pkg::ChBackslash);
  end

endmodule

// ===== rtl/core/csws_step.sv =====
// Next-state and output logic for one source byte.
module csws_step (
  input  csws_pkg::scan_state_t      state_i,
  input  logic [csws_pkg::ByteW-1:0] byte_i,
  input  csws_pkg::byte_class_t      class_i,
  input  logic                       end_i,
  input  logic [csws_pkg::LenW-1:0]  max_len_i,
  output csws_pkg::scan_state_t      state_o,
  output logic                       emit_o,
  output logic [csws_pkg::ByteW-1:0] word_byte_o,
  output logic                       word_last_o
);

  logic [csws_pkg::LenW-1:0] lim;
  logic                      cont;
  logic                      quote_hit;
  csws_pkg::scan_state_t     idle_st;

  assign lim       = (max_len_i == '0) ? csws_pkg::LenW'(1) : max_len_i;
  assign cont      = class_i.letter | class_i.digit | class_i.uscore;
  assign quote_hit = state_i.quote_dq ? class_i.dquote : class_i.squote;

  // Byte taken as if the scanner were idle.
  always_comb begin
    idle_st = csws_pkg::ScanReset;
    if (class_i.letter || class_i.uscore || class_i.hash) begin
      idle_st.mode     = csws_pkg::MODE_WORD;
      idle_st.held     = byte_i;
      idle_st.held_vld = 1'b1;
      idle_st.tok_len  = csws_pkg::LenW'(1);
    end else if (class_i.squote || class_i.dquote) begin
      idle_st.mode     = csws_pkg::MODE_LIT;
      idle_st.quote_dq = class_i.dquote;
      idle_st.tok_len  = csws_pkg::LenW'(1);
    end else if (class_i.slash) begin
      idle_st.mode     = csws_pkg::MODE_SLASH;
    end
  end

  always_comb begin
    state_o     = state_i;
    emit_o      = 1'b0;
    word_byte_o = state_i.held;
    word_last_o = 1'b1;
    if (end_i) begin
      emit_o  = state_i.held_vld;
      state_o = csws_pkg::ScanReset;
    end else begin
      case (state_i.mode)
        csws_pkg::MODE_WORD: begin
          emit_o = 1'b1;
          if (cont && (state_i.tok_len < lim)) begin
            word_last_o     = 1'b0;
            state_o.held    = byte_i;
            state_o.tok_len = state_i.tok_len + csws_pkg::LenW'(1);
          end else begin
            state_o = idle_st;
          end
        end
        csws_pkg::MODE_LIT: begin
          if (state_i.tok_len >= lim) begin
            state_o = idle_st;
          end else begin
            state_o.tok_len = state_i.tok_len + csws_pkg::LenW'(1);
            if (class_i.bslash) begin
              state_o.mode = csws_pkg::MODE_ESC;
            end else if (quote_hit) begin
              state_o = csws_pkg::ScanReset;
            end
          end
        end
        csws_pkg::MODE_ESC: begin
          state_o.mode = csws_pkg::MODE_LIT;
        end
        csws_pkg::MODE_SLASH: begin
          if (class_i.star) begin
            state_o.mode = csws_pkg::MODE_COMMENT;
          end else begin
            state_o = idle_st;
          end
        end
        csws_pkg::MODE_COMMENT: begin
          if (class_i.star) begin
            state_o.mode = csws_pkg::MODE_STAR;
          end
        end
        csws_pkg::MODE_STAR: begin
          if (class_i.slash) begin
            state_o = csws_pkg::ScanReset;
          end else if (!class_i.star) begin
            state_o.mode = csws_pkg::MODE_COMMENT;
          end
        end
        default: begin
          state_o = idle_st;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/c_source_word_scanner.sv =====
// Top level of the C source word scanner: state, limit and word registers.
//
// Scans C source text one byte per cycle when not stalled by in_ready_o and
// returns the bytes of each word (a letter, '_' or '#', then letters, digits
// or '_'), one byte per handshake, with word_last_o set on the final byte of
// each word. Whitespace and other bytes are dropped; quoted literals (with
// backslash escapes) and block comments are swallowed. One word byte is held
// inside until the next byte shows whether it ends its word, so output trails
// input by one byte. Words and literals are cut at cfg_data_i bytes (reset 99,
// 0 acts as 1); a new limit takes effect at the next byte. A byte with
// in_end_i set flushes the held byte and returns the scanner to idle.
// Throughput is one byte per cycle while in_ready_o is high: the mode update
// is a single pass of logic from the scan registers to the word register.
// in_ready_o follows word_ready_i while a word is waiting.
module c_source_word_scanner (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [csws_pkg::LenW-1:0]  cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [csws_pkg::ByteW-1:0] in_byte_i,
  input  logic                       in_end_i,
  output logic                       word_valid_o,
  input  logic                       word_ready_i,
  output logic [csws_pkg::ByteW-1:0] word_byte_o,
  output logic                       word_last_o
);

  logic [csws_pkg::LenW-1:0]  max_len_q;
  csws_pkg::scan_state_t      state_q, state_d;
  csws_pkg::byte_class_t      in_class;
  logic                       emit;
  logic [csws_pkg::ByteW-1:0] step_byte;
  logic                       step_last;
  logic                       in_fire;
  logic                       out_vld_q, out_vld_d;
  logic [csws_pkg::ByteW-1:0] out_byte_q, out_byte_d;
  logic                       out_last_q, out_last_d;

  // Take a byte whenever the word register is free or being drained.
  assign in_ready_o = !out_vld_q || word_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  csws_classify u_classify (
    .byte_i  (in_byte_i),
    .class_o (in_class)
  );

  csws_step u_step (
    .state_i     (state_q),
    .byte_i      (in_byte_i),
    .class_i     (in_class),
    .end_i       (in_end_i),
    .max_len_i   (max_len_q),
    .state_o     (state_d),
    .emit_o      (emit),
    .word_byte_o (step_byte),
    .word_last_o (step_last)
  );

  // Word register: loaded on an accepted byte, else cleared once taken.
  always_comb begin
    out_vld_d  = out_vld_q;
    out_byte_d = out_byte_q;
    out_last_d = out_last_q;
    if (in_fire) begin
      out_vld_d  = emit;
      out_byte_d = step_byte;
      out_last_d = step_last;
    end else if (word_ready_i) begin
      out_vld_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= csws_pkg::MaxLenReset;
      state_q   <= csws_pkg::ScanReset;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_data_i;
      end
      if (in_fire) begin
        state_q <= state_d;
      end
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign word_valid_o = out_vld_q;
  assign word_byte_o  = out_byte_q;
  assign word_last_o  = out_last_q;

endmodule
